### rtl/smhq_pkg.sv
// Shared types and codes for the severity min-heap queue.
`default_nettype none

package smhq_pkg;

    // Field widths of one record and of the result word
    localparam int SEV_W = 8;
    localparam int ID_W  = 16;
    localparam int REC_W = SEV_W + ID_W;
    localparam int OCC_W = 7;

    // Record: severity above id, so a plain unsigned compare orders both keys
    typedef logic [REC_W-1:0] t_rec;

    // Operation carried in the input tuser bit
    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    // Result status carried in the output tuser bits
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

endpackage

`default_nettype wire

### rtl/smhq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module smhq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

### rtl/severity_min_heap_queue.sv
// Binary min-heap priority queue of {severity, id} records held in one RAM.
//
//  channel  | dir | handshake                    | payload
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tuser: opcode; tdata: severity, patient_id
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tuser: status; tdata: record, empty, occupancy
//
// One request at a time. A push compares one parent per S_PU_CMP visit, then passes
// S_WB and S_DONE; a pop passes S_PO_ROOT and S_PO_LAST, then S_DN_L, S_DN_R and S_DN_C
// per level descended, stops in S_DN_L or S_DN_C, then passes S_WB and S_DONE.
// Popping the last record goes from S_PO_ROOT to S_DONE; rejected requests go straight
// to S_DONE. The pace is set by the single RAM read port: one parent or child per cycle.
// Reset (synchronous, active low) empties the queue; RAM contents are not cleared.
// A stalled result sits in the output register while the next request is taken;
// that request then waits at its end until the register is free.
`default_nettype none

module severity_min_heap_queue
    import smhq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [7:0] severity, [23:8] patient_id
    input  wire logic [0:0]  s_axis_tuser,   // [0] opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // [7:0] out_severity, [23:8] out_patient_id,
                                             // [24] queue_empty, [31:25] occupancy
    output logic      [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_PU_CMP  = 10'b00_0000_0010,
        S_PO_ROOT = 10'b00_0000_0100,
        S_PO_LAST = 10'b00_0000_1000,
        S_DN_L    = 10'b00_0001_0000,
        S_DN_R    = 10'b00_0010_0000,
        S_DN_C    = 10'b00_0100_0000,
        S_WB      = 10'b00_1000_0000,
        S_DONE    = 10'b01_0000_0000,
        S_SPARE   = 10'b10_0000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;      // committed occupancy
    logic [CW-1:0]    r_cnt, n_cnt;          // occupancy of the request at work
    logic [AW-1:0]    r_idx, n_idx;          // current hole
    logic [AW-1:0]    r_par, n_par;          // parent being read during sift-up
    t_rec             r_rec, n_rec;          // record being placed
    t_rec             r_lrec, n_lrec;        // left child record
    logic             r_has_r, n_has_r;      // right child exists
    t_rec             r_out_rec, n_out_rec;  // popped record
    t_status          r_status, n_status;
    logic             r_ovalid, n_ovalid;
    logic [31:0]      r_odata, n_odata;
    logic [1:0]       r_ouser, n_ouser;

    logic             w_wr_en;
    logic [AW-1:0]    w_wr_addr;
    t_rec             w_wr_data;
    logic [AW-1:0]    w_rd_addr;
    t_rec             w_rd_data;

    logic             w_accept;
    t_rec             w_in_rec;
    logic [XW-1:0]    w_left, w_right, w_cnt_x;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_in_rec      = {s_axis_tdata[7:0], s_axis_tdata[23:8]};

    // Child indices of the hole, wide enough to exceed the capacity
    assign w_left  = {1'b0, r_idx, 1'b1};
    assign w_right = {1'b0, r_idx, 1'b0} + XW'(2);
    assign w_cnt_x = XW'(r_cnt);

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    smhq_ram #(
        .WIDTH (REC_W),
        .DEPTH (CAPACITY)
    ) u_heap (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Sequencer: read, compare, write back one heap level at a time
    always_comb begin
        logic [AW-1:0] v_best_idx;
        t_rec          v_best_rec;

        n_state   = r_state;
        n_count   = r_count;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_par     = r_par;
        n_rec     = r_rec;
        n_lrec    = r_lrec;
        n_has_r   = r_has_r;
        n_out_rec = r_out_rec;
        n_status  = r_status;
        n_ovalid  = r_ovalid && !m_axis_tready;
        n_odata   = r_odata;
        n_ouser   = r_ouser;
        w_wr_en   = 1'b0;
        w_wr_addr = r_idx;
        w_wr_data = r_rec;
        w_rd_addr = '0;
        v_best_idx = r_idx;
        v_best_rec = r_rec;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_rec = '0;
                    n_status  = ST_OK;
                    n_cnt     = r_count;
                    if (t_op'(s_axis_tuser[0]) == OP_PUSH) begin
                        n_rec = w_in_rec;
                        n_idx = AW'(r_count);
                        if (r_count >= CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else if (r_count == '0) begin
                            n_cnt   = CW'(1);
                            n_state = S_WB;
                        end else begin
                            n_cnt     = r_count + CW'(1);
                            n_par     = AW'((r_count - CW'(1)) >> 1);
                            w_rd_addr = n_par;
                            n_state   = S_PU_CMP;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_cnt     = r_count - CW'(1);
                            w_rd_addr = '0;
                            n_state   = S_PO_ROOT;
                        end
                    end
                end
            end

            // Parent record has arrived: move it down or stop here
            S_PU_CMP: begin
                if (r_rec < w_rd_data) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_idx;
                    w_wr_data = w_rd_data;
                    n_idx     = r_par;
                    if (r_par == '0) begin
                        n_state = S_WB;
                    end else begin
                        n_par     = (r_par - AW'(1)) >> 1;
                        w_rd_addr = n_par;
                    end
                end else begin
                    n_state = S_WB;
                end
            end

            // Root arrives; fetch the last record
            S_PO_ROOT: begin
                n_out_rec = w_rd_data;
                w_rd_addr = AW'(r_cnt);
                n_state   = (r_cnt == '0) ? S_DONE : S_PO_LAST;
            end

            S_PO_LAST: begin
                n_rec   = w_rd_data;
                n_idx   = '0;
                n_state = S_DN_L;
            end

            // Sift-down: fetch left child, or place the record if there is none
            S_DN_L: begin
                if (w_left >= w_cnt_x) begin
                    n_state = S_WB;
                end else begin
                    w_rd_addr = AW'(w_left);
                    n_state   = S_DN_R;
                end
            end

            S_DN_R: begin
                n_lrec  = w_rd_data;
                n_has_r = (w_right < w_cnt_x);
                w_rd_addr = AW'(w_right);
                n_state = S_DN_C;
            end

            // Pick the smallest of record, left, right; ties keep the earlier
            S_DN_C: begin
                if (r_lrec < v_best_rec) begin
                    v_best_rec = r_lrec;
                    v_best_idx = AW'(w_left);
                end
                if (r_has_r && (w_rd_data < v_best_rec)) begin
                    v_best_rec = w_rd_data;
                    v_best_idx = AW'(w_right);
                end
                if (v_best_idx == r_idx) begin
                    n_state = S_WB;
                end else begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_idx;
                    w_wr_data = v_best_rec;
                    n_idx     = v_best_idx;
                    n_state   = S_DN_L;
                end
            end

            // Drop the moving record into the final hole
            S_WB: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_idx;
                w_wr_data = r_rec;
                n_state   = S_DONE;
            end

            // Hand the result to the output register once it is free
            S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = {OCC_W'(r_cnt), (r_cnt == '0),
                                r_out_rec[ID_W-1:0], r_out_rec[REC_W-1:ID_W]};
                    n_ouser  = r_status;
                    n_count  = r_cnt;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_idx     <= n_idx;
        r_par     <= n_par;
        r_rec     <= n_rec;
        r_lrec    <= n_lrec;
        r_has_r   <= n_has_r;
        r_out_rec <= n_out_rec;
        r_status  <= n_status;
        r_odata   <= n_odata;
        r_ouser   <= n_ouser;
    end

endmodule

`default_nettype wire

### rtl/smhq_checker.sv
// Port-level checks for the severity min-heap queue, bound to the top level.
`default_nettype none

module smhq_checker
    import smhq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    // A stalled result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // Only one request at work: input is closed right after a word is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted a second word while busy");

    // Rejected requests carry no record
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_FULL || m_axis_tuser == ST_EMPTY)
            |-> m_axis_tdata[23:0] == 24'd0)
        else $error("rejected request returned a record");

    // A pop on an empty queue leaves it empty
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_EMPTY |-> m_axis_tdata[24])
        else $error("empty pop reported records held");

    // Empty flag agrees with occupancy while it fits the field
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (CAPACITY >= 128)
            || (m_axis_tdata[24] == (m_axis_tdata[31:25] == 7'd0)))
        else $error("empty flag disagrees with occupancy");

endmodule

bind severity_min_heap_queue smhq_checker #(
    .CAPACITY (CAPACITY)
) u_smhq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
